// ----- rtl/atcw_pkg.sv -----
// ----------------------------------------------------------------------------
// atcw_pkg
// Types and constants shared by the text cell writer modules.
// ----------------------------------------------------------------------------
package atcw_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_DEFAULT = 2'd2;
  localparam logic [1:0] REG_BG      = 2'd3;

  localparam logic [7:0] BYTE_ESC  = 8'h1B;
  localparam logic [7:0] BYTE_LB   = 8'h5B;
  localparam logic [7:0] BYTE_M    = 8'h6D;
  localparam logic [7:0] BYTE_SEMI = 8'h3B;
  localparam logic [7:0] BYTE_ZERO = 8'h30;
  localparam logic [7:0] BYTE_NINE = 8'h39;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_TAB  = 8'h09;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_BS   = 8'h08;

  localparam logic [5:0] CODE_LO  = 6'd30;
  localparam logic [5:0] CODE_HI  = 6'd37;
  localparam logic [5:0] CODE_SAT = 6'd63;

  // Front-to-back command opcodes
  typedef enum logic [1:0] {
    OP_TEXT,   // run text rules on the byte
    OP_COLOR,  // load text color
    OP_END,    // string end: optional replay, then report
    OP_START   // reposition only
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;        // text byte
    logic [31:0] color;
    logic       first;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic       replay;      // OP_END: replay hold buffer
    logic [5:0] replay_cnt;
    logic       trunc;
    logic       last;        // last command from this item
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_REPLAY,
    BK_REPORT
  } bk_state_t;

  function automatic logic [31:0] vga_color(input logic [2:0] idx);
    case (idx)
      3'd0: vga_color = 32'hFF000000;
      3'd1: vga_color = 32'hFF0000AA;
      3'd2: vga_color = 32'hFF00AA00;
      3'd3: vga_color = 32'hFF0055AA;
      3'd4: vga_color = 32'hFFAA0000;
      3'd5: vga_color = 32'hFFAA00AA;
      3'd6: vga_color = 32'hFFAAAA00;
      default: vga_color = 32'hFFAAAAAA;
    endcase
  endfunction

endpackage

// ----- rtl/ansi_text_cell_writer_unit.sv -----
// One item per cycle while results are popped and no string end is pending;
// a write is registered in the cycle after its item is accepted. A string
// end, sent after any text of its item, holds the input until the report is
// issued. A pending escape sequence at string end replays the hold buffer (RAM
// read, then write, per held byte) before the report. Synchronous reset loads
// default cursor, escape state, text color and registers; hold RAM is kept.
module ansi_text_cell_writer_unit
  import atcw_pkg::*;
#(
  parameter int MAX_COLUMNS    = 256,
  parameter int MAX_ROWS       = 256,
  parameter int ESC_HOLD_DEPTH = 32,
  parameter int TAB_WIDTH      = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code,
  input  logic        first_of_string,
  input  logic [7:0]  start_x,
  input  logic [7:0]  start_y,
  input  logic        last_of_string,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  cell_x,
  output logic [7:0]  cell_y,
  output logic [15:0] glyph,
  output logic [31:0] fg_color,
  output logic [31:0] bg_color,
  output logic        replay_truncated,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(ESC_HOLD_DEPTH);

  logic [8:0]  columns, rows;
  logic [31:0] background_color;
  logic        in_ready, cmd_valid, cmd_ready, res_valid;
  cmd_t        cmd;
  logic        hold_we, replay_busy;
  logic [AW-1:0] hold_waddr, hold_raddr;
  logic [7:0]  hold_wdata, hold_rdata;

  assign full  = !in_ready;
  assign empty = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= 9'd80; rows <= 9'd25; background_color <= 32'hFF000000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: columns <= cfg_data[8:0];
        REG_ROWS:    rows <= cfg_data[8:0];
        REG_BG:      background_color <= cfg_data;
        default: ;
      endcase
    end
  end

  atcw_front #(.HOLD_DEPTH(ESC_HOLD_DEPTH)) u_front (
    .clk, .rst, .in_valid(push), .in_ready, .char_code, .first_of_string,
    .start_x, .start_y, .last_of_string, .cmd_valid, .cmd_ready, .cmd,
    .hold_we, .hold_waddr, .hold_wdata, .replay_busy
  );

  atcw_ram #(.WIDTH(8), .DEPTH(ESC_HOLD_DEPTH)) u_hold (
    .clk, .we(hold_we), .waddr(hold_waddr), .wdata(hold_wdata),
    .raddr(hold_raddr), .rdata(hold_rdata)
  );

  atcw_back #(
    .MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS),
    .HOLD_DEPTH(ESC_HOLD_DEPTH), .TAB_WIDTH(TAB_WIDTH)
  ) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd, .columns, .rows,
    .color_load(cfg_we && cfg_index == REG_DEFAULT), .color_value(cfg_data),
    .background_color, .hold_raddr, .hold_rdata, .replay_busy,
    .res_valid, .res_ready(pop), .kind, .cell_x, .cell_y, .glyph,
    .fg_color, .bg_color, .replay_truncated, .last_of_run
  );

endmodule

// ----- rtl/atcw_ram.sv -----
// ----------------------------------------------------------------------------
// atcw_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module atcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/atcw_front.sv -----
// ----------------------------------------------------------------------------
// atcw_front
// Escape parser: folds SGR sequences, fills the hold buffer, and issues
// commands for the back end.
// ----------------------------------------------------------------------------
module atcw_front
  import atcw_pkg::*;
#(
  parameter int HOLD_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    char_code,
  input  logic                          first_of_string,
  input  logic [7:0]                    start_x,
  input  logic [7:0]                    start_y,
  input  logic                          last_of_string,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output cmd_t                          cmd,
  output logic                          hold_we,
  output logic [$clog2(HOLD_DEPTH)-1:0] hold_waddr,
  output logic [7:0]                    hold_wdata,
  input  logic                          replay_busy
);

  localparam int CW = $clog2(HOLD_DEPTH + 1);

  logic [1:0]    phase, phase_next;
  logic          semi, semi_next;
  logic [5:0]    code, code_next;
  logic          digits, digits_next;
  logic          bad, bad_next;
  logic [CW-1:0] held, held_next;
  logic          ovf, ovf_next;

  // second command of an item (end after text) waits here
  logic          pend;
  cmd_t          pend_cmd;

  logic          take;
  logic [1:0]    ph;
  logic          sm, dg, bd, ov;
  logic [5:0]    cd;
  logic [CW-1:0] hc;
  logic          want_a, want_b;
  cmd_t          cmd_a, cmd_b;
  logic [9:0]    mul;
  logic [5:0]    code_m30;

  // replay reads the hold buffer, so stall new items until it is done
  assign in_ready = !pend && cmd_ready && !replay_busy;
  assign take     = in_valid && in_ready;

  always_comb begin
    ph = first_of_string ? 2'd0 : phase;
    sm = first_of_string ? 1'b0 : semi;
    cd = first_of_string ? '0 : code;
    dg = first_of_string ? 1'b0 : digits;
    bd = first_of_string ? 1'b0 : bad;
    hc = first_of_string ? '0 : held;
    ov = first_of_string ? 1'b0 : ovf;
    phase_next = ph; semi_next = sm; code_next = cd; digits_next = dg;
    bad_next = bd; held_next = hc; ovf_next = ov;
    hold_we = 1'b0;
    hold_waddr = hc[$clog2(HOLD_DEPTH)-1:0];
    hold_wdata = char_code;
    mul = {4'd0, cd} * 10'd10 + {6'd0, char_code[3:0]};
    code_m30 = cd - CODE_LO;
    want_a = 1'b0;
    cmd_a = '0;
    cmd_a.first = first_of_string;
    cmd_a.start_x = start_x;
    cmd_a.start_y = start_y;
    cmd_a.data = char_code;
    cmd_a.op = OP_TEXT;
    case (ph)
      2'd2: begin
        if (char_code == BYTE_M) begin
          if (dg && !bd && cd >= CODE_LO && cd <= CODE_HI) begin
            want_a = 1'b1;
            cmd_a.op = OP_COLOR;
            cmd_a.color = vga_color(code_m30[2:0]);
          end
          phase_next = 2'd0; semi_next = 1'b0; code_next = '0;
          digits_next = 1'b0; bad_next = 1'b0; held_next = '0; ovf_next = 1'b0;
        end else begin
          if (hc < CW'(HOLD_DEPTH)) begin
            hold_we = take;
            held_next = hc + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          if (char_code == BYTE_SEMI && !sm) begin
            semi_next = 1'b1; code_next = '0; digits_next = 1'b0; bad_next = 1'b0;
          end else if (char_code >= BYTE_ZERO && char_code <= BYTE_NINE) begin
            code_next = (mul > 10'd63) ? CODE_SAT : mul[5:0];
            digits_next = 1'b1;
          end else begin
            bad_next = 1'b1;
          end
        end
      end
      2'd1: begin
        if (char_code == BYTE_LB) begin
          phase_next = 2'd2; semi_next = 1'b0; code_next = '0;
          digits_next = 1'b0; bad_next = 1'b0; held_next = '0; ovf_next = 1'b0;
        end else if (char_code != BYTE_ESC) begin
          phase_next = 2'd0;
          want_a = 1'b1;
        end
      end
      default: begin
        if (char_code == BYTE_ESC) begin
          phase_next = 2'd1;
        end else begin
          want_a = 1'b1;
        end
      end
    endcase
    // a start position still has to reach the cursor
    if (!want_a && first_of_string) begin
      want_a = 1'b1;
      cmd_a.op = OP_START;
    end
    want_b = last_of_string;
    cmd_b = '0;
    cmd_b.op = OP_END;
    cmd_b.replay = (phase_next == 2'd2);
    cmd_b.replay_cnt = 6'(held_next);
    cmd_b.trunc = (phase_next == 2'd2) && ovf_next;
    cmd_b.last = 1'b1;
    cmd_a.last = !want_b;
    if (last_of_string) begin
      phase_next = 2'd0; semi_next = 1'b0; code_next = '0;
      digits_next = 1'b0; bad_next = 1'b0; held_next = '0; ovf_next = 1'b0;
    end
    if (!want_a && want_b) begin
      cmd_a = cmd_b;
    end
    if (pend) begin
      cmd = pend_cmd;
      cmd_valid = 1'b1;
    end else begin
      cmd = cmd_a;
      cmd_valid = take && (want_a || want_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0; semi <= 1'b0; code <= '0; digits <= 1'b0;
      bad <= 1'b0; held <= '0; ovf <= 1'b0; pend <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next; semi <= semi_next; code <= code_next;
        digits <= digits_next; bad <= bad_next; held <= held_next; ovf <= ovf_next;
        pend <= want_a && want_b;
      end else if (pend && cmd_ready) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_cmd <= cmd_b;
    end
  end

  assert property (@(posedge clk) disable iff (rst) pend |-> !in_ready)
    else $error("item taken while a command is pending");
  assert property (@(posedge clk) disable iff (rst) held <= CW'(HOLD_DEPTH))
    else $error("hold count past depth");
  assert property (@(posedge clk) disable iff (rst)
    take && last_of_string |=> phase == 2'd0)
    else $error("escape state kept past string end");

endmodule

// ----- rtl/atcw_back.sv -----
// ----------------------------------------------------------------------------
// atcw_back
// Cursor engine: executes commands, replays held bytes, emits cell writes.
// ----------------------------------------------------------------------------
module atcw_back
  import atcw_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256,
  parameter int HOLD_DEPTH  = 32,
  parameter int TAB_WIDTH   = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  cmd_t                          cmd,
  input  logic [8:0]                    columns,
  input  logic [8:0]                    rows,
  input  logic                          color_load,
  input  logic [31:0]                   color_value,
  input  logic [31:0]                   background_color,
  output logic [$clog2(HOLD_DEPTH)-1:0] hold_raddr,
  input  logic [7:0]                    hold_rdata,
  output logic                          replay_busy,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [1:0]                    kind,
  output logic [7:0]                    cell_x,
  output logic [7:0]                    cell_y,
  output logic [15:0]                   glyph,
  output logic [31:0]                   fg_color,
  output logic [31:0]                   bg_color,
  output logic                          replay_truncated,
  output logic                          last_of_run
);

  localparam int AW = $clog2(HOLD_DEPTH);
  localparam int CLIM = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
  localparam int RLIM = (MAX_ROWS < 256) ? MAX_ROWS : 256;

  bk_state_t     state, state_next;
  logic [7:0]    cx, cy, bcol;
  logic [31:0]   tcolor;
  logic [5:0]    rcnt, ridx;
  logic          aesc, trunc;
  logic [8:0]    cols, rws;

  // text engine
  logic          t_go;
  logic [7:0]    t_byte;
  logic [7:0]    tx, ty, bx;
  logic [7:0]    nx, ny;
  logic          t_emit;
  logic [1:0]    t_kind;
  logic [7:0]    t_ex;
  logic          t_last;
  logic          out_free;
  logic          do_cmd, rep_step, rep_use;

  assign cols = (columns > 9'(CLIM)) ? 9'(CLIM) : columns;
  assign rws  = (rows > 9'(RLIM)) ? 9'(RLIM) : rows;
  assign out_free = !res_valid || res_ready;
  assign cmd_ready = (state == BK_IDLE) && out_free;
  assign replay_busy = (state != BK_IDLE);
  assign do_cmd = cmd_valid && cmd_ready;
  assign hold_raddr = ridx[AW-1:0];
  assign rep_step = (state == BK_REPLAY) && out_free;
  // skip '[' after ESC and the ESC itself
  assign rep_use = !(aesc && hold_rdata == BYTE_LB) && hold_rdata != BYTE_ESC;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (do_cmd && cmd.op == OP_END) begin
          state_next = (cmd.replay && cmd.replay_cnt != 0) ? BK_READ : BK_REPORT;
        end
      end
      BK_READ:   state_next = BK_REPLAY;
      BK_REPLAY: begin
        if (rep_step) begin
          state_next = (ridx + 6'd1 == rcnt) ? BK_REPORT : BK_READ;
        end
      end
      BK_REPORT: if (out_free) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    tx = (do_cmd && cmd.first) ? cmd.start_x : cx;
    ty = (do_cmd && cmd.first) ? cmd.start_y : cy;
    bx = (do_cmd && cmd.first) ? cmd.start_x : bcol;
    t_go = (do_cmd && cmd.op == OP_TEXT) || (rep_step && rep_use);
    t_byte = (state == BK_REPLAY) ? hold_rdata : cmd.data;
    t_last = (state == BK_REPLAY) ? 1'b0 : cmd.last;
    nx = tx; ny = ty;
    t_emit = 1'b0; t_kind = KIND_WRITE; t_ex = tx;
    case (t_byte)
      BYTE_LF:  if ({1'b0, ty} + 9'd1 < rws) ny = ty + 8'd1;
      BYTE_TAB: if ({1'b0, tx} + 9'(TAB_WIDTH) < cols) nx = tx + 8'(TAB_WIDTH);
      BYTE_CR:  nx = bx;
      BYTE_BS: begin
        if (tx > bx) begin
          nx = tx - 8'd1; t_emit = 1'b1; t_kind = KIND_CLEAR; t_ex = tx - 8'd1;
        end
      end
      default: begin
        t_emit = 1'b1;
        if ({1'b0, tx} + 9'd1 < cols) begin
          nx = tx + 8'd1;
        end else if ({1'b0, ty} + 9'd1 < rws) begin
          ny = ty + 8'd1; nx = bx;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      cx <= '0; cy <= '0; bcol <= '0;
      tcolor <= 32'hFFFFFFFF;
      res_valid <= 1'b0;
      ridx <= '0; rcnt <= '0; aesc <= 1'b0; trunc <= 1'b0;
    end else begin
      state <= state_next;
      if (color_load) begin
        tcolor <= color_value;
      end else if (do_cmd && cmd.op == OP_COLOR) begin
        tcolor <= cmd.color;
      end
      if (t_go) begin
        cx <= nx; cy <= ny;
      end else if (do_cmd && cmd.first) begin
        cx <= cmd.start_x; cy <= cmd.start_y;
      end
      if (do_cmd && cmd.first) bcol <= cmd.start_x;
      if (do_cmd && cmd.op == OP_END) begin
        rcnt <= cmd.replay_cnt; ridx <= '0; aesc <= 1'b0; trunc <= cmd.trunc;
      end else if (rep_step) begin
        ridx <= ridx + 6'd1;
        aesc <= (hold_rdata == BYTE_ESC) && !(aesc && hold_rdata == BYTE_LB);
      end
      if ((t_go && t_emit) || (state == BK_REPORT && out_free)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (state == BK_REPORT && out_free) begin
      kind <= KIND_END; cell_x <= cx; cell_y <= cy; glyph <= '0;
      fg_color <= '0; bg_color <= '0; replay_truncated <= trunc; last_of_run <= 1'b1;
    end else if (t_go && t_emit) begin
      kind <= t_kind; cell_x <= t_ex; cell_y <= ty;
      glyph <= (t_kind == KIND_WRITE) ? {{8{t_byte[7]}}, t_byte} : 16'd0;
      fg_color <= (t_kind == KIND_WRITE) ? tcolor : 32'd0;
      bg_color <= (t_kind == KIND_WRITE) ? background_color : 32'd0;
      replay_truncated <= 1'b0;
      last_of_run <= t_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    state == BK_REPLAY |-> ridx < rcnt)
    else $error("replay index past count");
  assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> state == BK_IDLE)
    else $error("command taken during replay");

endmodule

// ----- bench/ansi_text_cell_writer_unit_test.sv -----
// ----------------------------------------------------------------------------
// ansi_text_cell_writer_unit_test
// Streams strings of bytes into the text cell writer under random push and
// pop gaps and several grid and color settings, and checks every cell write,
// glyph clear and end-of-string cursor report against an in-bench predictor.
// ----------------------------------------------------------------------------
module ansi_text_cell_writer_unit_test;
  import atcw_pkg::*;

  localparam int GRID_MAX   = 256;
  localparam int HOLD_DEPTH = 32;
  localparam int TAB_STEP   = 4;
  localparam int IDLE_PCT   = 17;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [7:0] code;
    logic       first;
    logic [7:0] sx;
    logic [7:0] sy;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] glyph;
    logic [31:0] fg;
    logic [31:0] bg;
    logic        trunc;
    logic        last;
  } cell_op_t;

  logic        clk, rst, push, full, empty, pop;
  logic [7:0]  char_code, start_x, start_y;
  logic        first_of_string, last_of_string;
  logic [1:0]  kind;
  logic [7:0]  cell_x, cell_y;
  logic [15:0] glyph;
  logic [31:0] fg_color, bg_color;
  logic        replay_truncated, last_of_run;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  ansi_text_cell_writer_unit u_top (.*);

  byte_item_t pending_bytes[$];
  cell_op_t   expected_cells[$];
  int         mismatches = 0;
  logic       calm = 0;
  logic       byte_taken = 0;
  int         quiet_cycles = 0;

  // predictor state
  logic [8:0]  grid_cols, grid_rows;
  logic [31:0] dflt_color, back_color, pen_color;
  logic [7:0]  cur_x, cur_y, left_col;
  int          esc_state;
  logic        semi_seen, digits_seen, code_bad, hold_over;
  int          code_val, hold_cnt;
  logic [7:0]  hold_buf[HOLD_DEPTH];

  function automatic int grid_limit(logic [8:0] v);
    return (v > GRID_MAX) ? GRID_MAX : int'(v);
  endfunction

  function automatic logic [31:0] sgr_color(int idx);
    case (idx)
      0: return 32'hFF000000;
      1: return 32'hFF0000AA;
      2: return 32'hFF00AA00;
      3: return 32'hFF0055AA;
      4: return 32'hFFAA0000;
      5: return 32'hFFAA00AA;
      6: return 32'hFFAAAA00;
      default: return 32'hFFAAAAAA;
    endcase
  endfunction

  task automatic add_cell(logic [1:0] k, logic [15:0] g, logic [31:0] f, logic [31:0] b,
                          logic t);
    cell_op_t c;
    c = '{kind: k, x: cur_x, y: cur_y, glyph: g, fg: f, bg: b, trunc: t, last: 1'b0};
    expected_cells.push_back(c);
  endtask

  task automatic drop_escape();
    esc_state = 0;
    semi_seen = 0;
    code_val = 0;
    digits_seen = 0;
    code_bad = 0;
    hold_cnt = 0;
    hold_over = 0;
  endtask

  task automatic place_text(logic [7:0] c);
    int cols;
    int rws;
    cols = grid_limit(grid_cols);
    rws = grid_limit(grid_rows);
    case (c)
      BYTE_LF: if (int'(cur_y) + 1 < rws) cur_y++;
      BYTE_TAB: if (int'(cur_x) + TAB_STEP < cols) cur_x = cur_x + 8'(TAB_STEP);
      BYTE_CR: cur_x = left_col;
      BYTE_BS: if (cur_x > left_col) begin
        cur_x--;
        add_cell(KIND_CLEAR, 16'h0, 32'h0, 32'h0, 1'b0);
      end
      default: begin
        add_cell(KIND_WRITE, {{8{c[7]}}, c}, pen_color, back_color, 1'b0);
        if (int'(cur_x) + 1 < cols) cur_x++;
        else if (int'(cur_y) + 1 < rws) begin
          cur_y++;
          cur_x = left_col;
        end
      end
    endcase
  endtask

  task automatic replay_hold();
    logic after_esc;
    after_esc = 0;
    for (int i = 0; i < hold_cnt && i < HOLD_DEPTH; i++) begin
      if (after_esc && hold_buf[i] == BYTE_LB) begin
        after_esc = 0;
      end else begin
        after_esc = 0;
        if (hold_buf[i] == BYTE_ESC) after_esc = 1;
        else place_text(hold_buf[i]);
      end
    end
  endtask

  task automatic take_code_byte(logic [7:0] c);
    if (c == BYTE_SEMI && !semi_seen) begin
      semi_seen = 1;
      code_val = 0;
      digits_seen = 0;
      code_bad = 0;
    end else if (c >= BYTE_ZERO && c <= BYTE_NINE) begin
      code_val = code_val * 10 + int'(c - BYTE_ZERO);
      if (code_val > 63) code_val = 63;
      digits_seen = 1;
    end else begin
      code_bad = 1;
    end
  endtask

  task automatic predict_cells(byte_item_t it);
    int n_prior;
    n_prior = expected_cells.size();
    if (it.first) begin
      cur_x = it.sx;
      cur_y = it.sy;
      left_col = it.sx;
      drop_escape();
    end
    if (esc_state == 2) begin
      if (it.code == BYTE_M) begin
        if (digits_seen && !code_bad && code_val >= 30 && code_val <= 37)
          pen_color = sgr_color(code_val - 30);
        drop_escape();
      end else begin
        if (hold_cnt < HOLD_DEPTH) begin
          hold_buf[hold_cnt] = it.code;
          hold_cnt++;
        end else hold_over = 1;
        take_code_byte(it.code);
      end
    end else if (esc_state == 1) begin
      if (it.code == BYTE_LB) begin
        drop_escape();
        esc_state = 2;
      end else if (it.code != BYTE_ESC) begin
        esc_state = 0;
        place_text(it.code);
      end
    end else begin
      if (it.code == BYTE_ESC) esc_state = 1;
      else place_text(it.code);
    end
    if (it.last) begin
      logic t;
      t = 0;
      if (esc_state == 2) begin
        replay_hold();
        t = hold_over;
      end
      add_cell(KIND_END, 16'h0, 32'h0, 32'h0, t);
      drop_escape();
    end
    if (expected_cells.size() > n_prior)
      expected_cells[expected_cells.size() - 1].last = 1'b1;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_COLUMNS: grid_cols = val[8:0];
      REG_ROWS: grid_rows = val[8:0];
      REG_DEFAULT: begin
        dflt_color = val;
        pen_color = val;
      end
      default: back_color = val;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic add_byte(logic [7:0] c, logic f = 0, logic l = 0);
    byte_item_t it;
    it = '{code: c, first: f, sx: 8'($urandom), sy: 8'($urandom), last: l};
    // start near the grid most of the time, anywhere now and then
    if (f && $urandom_range(3) != 0) begin
      it.sx = 8'($urandom_range(grid_limit(grid_cols) > 0 ? grid_limit(grid_cols) - 1 : 0));
      it.sy = 8'($urandom_range(grid_limit(grid_rows) > 0 ? grid_limit(grid_rows) - 1 : 0));
    end
    pending_bytes.push_back(it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_color_seq(logic good);
    add_byte(BYTE_ESC);
    add_byte(BYTE_LB);
    if ($urandom_range(1)) begin
      add_byte(8'h31);
      add_byte(BYTE_SEMI);
    end
    if ($urandom_range(3) == 0) add_byte(BYTE_ZERO);
    if (good) begin
      add_byte(8'h33);
      add_byte(8'h30 + 8'($urandom_range(7)));
    end else begin
      case ($urandom_range(3))
        0: add_byte(8'h2D);
        1: add_byte(BYTE_SEMI);
        2: repeat (3) add_byte(8'h30 + 8'($urandom_range(9)));
        default: add_byte(8'($urandom));
      endcase
    end
    add_byte(BYTE_M);
  endtask

  task automatic add_string(int target);
    int n0;
    n0 = pending_bytes.size();
    add_byte(8'h20 + 8'($urandom_range(94)), 1'b1);
    while (pending_bytes.size() - n0 < target) begin
      case ($urandom_range(9))
        0, 1, 2: add_byte(8'($urandom));
        3: add_byte($urandom_range(1) ? BYTE_LF : BYTE_TAB);
        4: add_byte($urandom_range(1) ? BYTE_CR : BYTE_BS);
        5, 6: add_color_seq(1'b1);
        7: add_color_seq(1'b0);
        8: begin
          add_byte(BYTE_ESC);
          add_byte(8'h41 + 8'($urandom_range(25)));
        end
        default: add_byte(8'h80 + 8'($urandom_range(127)));
      endcase
    end
    case ($urandom_range(7))
      0: begin
        // hold an unterminated sequence to the end, sometimes past the buffer
        add_byte(BYTE_ESC);
        add_byte(BYTE_LB);
        repeat ($urandom_range(1) ? $urandom_range(6) : 30 + $urandom_range(6)) begin
          case ($urandom_range(5))
            0: add_byte(BYTE_ESC);
            1: add_byte(BYTE_LB);
            2: add_byte(BYTE_BS);
            default: add_byte(8'($urandom));
          endcase
        end
        if (pending_bytes[$].code == BYTE_M) pending_bytes[$].code = 8'h41;
        add_byte(8'h41, 1'b0, 1'b1);
        if ($urandom_range(1)) pending_bytes[$].code = BYTE_ESC;
      end
      1: begin
        // drop the string end: next string discards any pending sequence
        add_byte(BYTE_ESC);
        add_byte(BYTE_LB);
        add_byte(8'h33);
      end
      default: add_byte(8'($urandom), 1'b0, 1'b1);
    endcase
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || push || expected_cells.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int nbytes);
    int n0;
    n0 = pending_bytes.size();
    while (pending_bytes.size() - n0 < nbytes) add_string(4 + $urandom_range(20));
    wait_idle();
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // input side: present the next item, hold it until taken
  always @(negedge clk) begin
    if (rst) begin
      push <= 0;
      char_code <= 0;
      first_of_string <= 0;
      start_x <= 0;
      start_y <= 0;
      last_of_string <= 0;
    end else if (!push || byte_taken) begin
      if (pending_bytes.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        byte_item_t it;
        it = pending_bytes.pop_front();
        push <= 1;
        char_code <= it.code;
        first_of_string <= it.first;
        start_x <= it.sx;
        start_y <= it.sy;
        last_of_string <= it.last;
      end else begin
        push <= 0;
      end
    end
  end

  always @(negedge clk) begin
    pop <= !rst && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    byte_taken <= push && !full && !rst;
    if (!rst) begin
      if (push && !full)
        predict_cells('{code: char_code, first: first_of_string, sx: start_x,
                        sy: start_y, last: last_of_string});
      if (pop && !empty) begin
        cell_op_t got;
        got = '{kind: kind, x: cell_x, y: cell_y, glyph: glyph, fg: fg_color,
                bg: bg_color, trunc: replay_truncated, last: last_of_run};
        if (expected_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected cell op %p", got);
        end else begin
          cell_op_t want;
          want = expected_cells.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("cell op mismatch: expected %p got %p", want, got);
          end
        end
      end
      if ((push && !full) || (pop && !empty) || cfg_we) quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_COLUMNS;
    cfg_data = 0;
    grid_cols = 80;
    grid_rows = 25;
    dflt_color = 32'hFFFFFFFF;
    back_color = 32'hFF000000;
    pen_color = dflt_color;
    cur_x = 0;
    cur_y = 0;
    left_col = 0;
    drop_escape();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: edges of the byte range, controls and the sequence cases
    add_byte(8'h00, 1'b1);
    pending_bytes[$].sx = 8'd78;
    pending_bytes[$].sy = 8'd0;
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(BYTE_LF);
    add_byte(BYTE_TAB);
    add_byte(BYTE_BS);
    add_byte(BYTE_CR);
    add_byte(BYTE_BS);
    add_text("\033[1;0034m");
    add_byte(8'h41);
    add_text("\033\033[99m");
    add_text("\033X\033[;m");
    add_byte(BYTE_ESC, 1'b0, 1'b1);
    add_byte(BYTE_ESC, 1'b1);
    pending_bytes[$].sx = 8'd255;
    pending_bytes[$].sy = 8'd255;
    add_byte(BYTE_LB);
    add_byte(8'h5A, 1'b0, 1'b1);
    wait_idle();
    random_phase(50);

    write_reg(REG_COLUMNS, 32'd1);
    write_reg(REG_ROWS, 32'd1);
    write_reg(REG_DEFAULT, 32'h0);
    write_reg(REG_BG, 32'hFFFFFFFF);
    random_phase(50);

    calm = 1;
    write_reg(REG_COLUMNS, 32'd256);
    write_reg(REG_ROWS, 32'd256);
    write_reg(REG_DEFAULT, $urandom);
    write_reg(REG_BG, 32'h0);
    random_phase(55);
    calm = 0;

    write_reg(REG_COLUMNS, 32'd0);
    write_reg(REG_ROWS, 32'd0);
    random_phase(50);

    write_reg(REG_COLUMNS, 32'd511);
    write_reg(REG_ROWS, 32'd300);
    write_reg(REG_DEFAULT, 32'hFFFFFFFF);
    write_reg(REG_BG, $urandom);
    random_phase(55);

    write_reg(REG_COLUMNS, 32'd5 + 32'($urandom_range(20)));
    write_reg(REG_ROWS, 32'd2 + 32'($urandom_range(6)));
    random_phase(50);

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
